// ===== rtl/sinusoid_breakpoint_morph_core_macros.svh =====
// assertion helpers shared by the rtl
`ifndef SINUSOID_BREAKPOINT_MORPH_CORE_MACROS_SVH
`define SINUSOID_BREAKPOINT_MORPH_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sbm assertion failed");

// next-cycle implication, disabled during reset
`define SBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sbm assertion failed");

`endif

// ===== rtl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Widths, stage counts and the exp2 factor table of the breakpoint morpher.
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

  localparam int FREQ_W   = 24;
  localparam int AMP_W    = 24;
  localparam int BW_W     = 17;
  localparam int PH_W     = 17;
  localparam int W_W      = 17;
  localparam int LOG_FRAC = 28;
  localparam int X_W      = AMP_W + 1;
  localparam int E_W      = 5;
  localparam int LOG_W    = E_W + LOG_FRAC;
  localparam int M_W      = 32;
  localparam int PADJ_W   = PH_W + 2;
  localparam int PB_W     = 38;

  localparam logic [W_W-1:0] W_ONE = W_W'(65536);
  localparam logic [AMP_W-1:0] AMP_MAX = '1;
  localparam logic [AMP_W-1:0] SHAPE_RST = AMP_W'(168);

  // global pipeline: entry, log2 (29), blend, exp2 (29), output
  localparam int LOG_STG = LOG_FRAC + 1;
  localparam int EXP_STG = LOG_FRAC + 1;
  localparam int STG_LOG_OUT = 1 + LOG_STG;
  localparam int STG_BLEND = STG_LOG_OUT + 1;
  localparam int STG_EXP_OUT = STG_BLEND + EXP_STG;
  localparam int NSTG = STG_EXP_OUT + 1;

  typedef struct packed {
    logic [FREQ_W-1:0]        freq;
    logic [BW_W-1:0]          bw;
    logic signed [PH_W-1:0]   phase;
    logic [W_W-1:0]           wa;
    logic                     byp;
    logic [AMP_W-1:0]         byp_val;
  } side_t;

  typedef logic [LOG_FRAC:0][M_W-1:0] fac_arr_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor i is 2^(2^-i) in q1.31, each the floor root of the one before
  function automatic fac_arr_t fac_table();
    fac_arr_t    t;
    logic [63:0] f;
    t = '0;
    f = 64'd1 << 32;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      f = isqrt64(f << 31);
      t[i] = f[M_W-1:0];
    end
    return t;
  endfunction

  localparam fac_arr_t FAC = fac_table();

endpackage

`default_nettype wire

// ===== rtl/sbm_log2.sv =====
// ----------------------------------------------------------------------------
// sbm_log2
// Pipelined log2: normalize stage, then one squaring per stage for each
// fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_log2 (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [sbm_pkg::X_W-1:0]     x_i,
  output logic      [sbm_pkg::LOG_W-1:0]   l_o
);

  logic [sbm_pkg::M_W-1:0]   m_q [0:sbm_pkg::LOG_FRAC];
  logic [sbm_pkg::LOG_W-1:0] r_q [0:sbm_pkg::LOG_FRAC];
  logic [sbm_pkg::E_W-1:0]   e;
  logic [sbm_pkg::M_W-1:0]   m_d;

  // top set bit
  always_comb begin
    e = '0;
    for (int k = 0; k < sbm_pkg::X_W; k++) begin
      if (x_i[k]) begin
        e = sbm_pkg::E_W'(k);
      end
    end
    m_d = sbm_pkg::M_W'(x_i) << (sbm_pkg::E_W'(31) - e);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m_d;
      r_q[0] <= {e, {sbm_pkg::LOG_FRAC{1'b0}}};
    end
  end

  for (genvar i = 1; i <= sbm_pkg::LOG_FRAC; i++) begin : g_sq
    logic [2*sbm_pkg::M_W-1:0] sq;
    logic [sbm_pkg::M_W:0]     t;
    logic [sbm_pkg::M_W-1:0]   m_d_i;
    logic [sbm_pkg::LOG_W-1:0] r_d_i;

    always_comb begin
      sq = m_q[i-1] * m_q[i-1];
      t  = sq[2*sbm_pkg::M_W-1:sbm_pkg::M_W-1];
      r_d_i = r_q[i-1];
      if (t[sbm_pkg::M_W]) begin
        m_d_i = t[sbm_pkg::M_W:1];
        r_d_i[sbm_pkg::LOG_FRAC-i] = 1'b1;
      end else begin
        m_d_i = t[sbm_pkg::M_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i] <= m_d_i;
        r_q[i] <= r_d_i;
      end
    end
  end

  assign l_o = r_q[sbm_pkg::LOG_FRAC];

endmodule

`default_nettype wire

// ===== rtl/sbm_exp2.sv =====
// ----------------------------------------------------------------------------
// sbm_exp2
// Pipelined exp2: one table factor multiply per fraction bit, then the
// integer scale with round half up.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_exp2 (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [sbm_pkg::LOG_W-1:0]   l_i,
  output logic      [sbm_pkg::LOG_W-1:0]   r_o
);

  logic [sbm_pkg::M_W-1:0]   acc_q [1:sbm_pkg::LOG_FRAC];
  logic [sbm_pkg::LOG_W-1:0] l_q   [1:sbm_pkg::LOG_FRAC];
  logic [sbm_pkg::LOG_W-1:0] r_q;

  for (genvar i = 1; i <= sbm_pkg::LOG_FRAC; i++) begin : g_mul
    logic [sbm_pkg::M_W-1:0]   acc_in;
    logic [sbm_pkg::LOG_W-1:0] l_in;
    logic [2*sbm_pkg::M_W-1:0] prod;
    logic [sbm_pkg::M_W-1:0]   acc_d_i;

    if (i == 1) begin : g_first
      assign acc_in = sbm_pkg::M_W'(64'd1 << 31);
      assign l_in   = l_i;
    end else begin : g_rest
      assign acc_in = acc_q[i-1];
      assign l_in   = l_q[i-1];
    end

    always_comb begin
      prod = acc_in * sbm_pkg::FAC[i];
      if (l_in[sbm_pkg::LOG_FRAC-i]) begin
        acc_d_i = prod[2*sbm_pkg::M_W-2:sbm_pkg::M_W-1];
      end else begin
        acc_d_i = acc_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i] <= acc_d_i;
        l_q[i]   <= l_in;
      end
    end
  end

  logic [sbm_pkg::E_W-1:0]   n;
  logic [sbm_pkg::E_W:0]     sh;
  logic [sbm_pkg::LOG_W-1:0] rnd;
  logic [sbm_pkg::LOG_W-1:0] r_d;

  // integer part never exceeds the input exponent, so a right shift suffices
  always_comb begin
    n   = l_q[sbm_pkg::LOG_FRAC][sbm_pkg::LOG_W-1:sbm_pkg::LOG_FRAC];
    sh  = (sbm_pkg::E_W+1)'(31) - {1'b0, n};
    rnd = sbm_pkg::LOG_W'(acc_q[sbm_pkg::LOG_FRAC])
        + (sbm_pkg::LOG_W'(1) << (sh - (sbm_pkg::E_W+1)'(1)));
    r_d = rnd >> sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/sinusoid_breakpoint_morph_core.sv =====
// the depth from input accept to result valid is dominated by the 29-stage
// log2 and 29-stage exp2 pipelines of the amplitude path
// throughput: one item per cycle; the whole pipeline stalls only while the
// output register holds an item not yet taken
// reset: valid bits clear, amp_shape returns to 168
`default_nettype none

`include "sinusoid_breakpoint_morph_core_macros.svh"

// ----------------------------------------------------------------------------
// sinusoid_breakpoint_morph_core
// Morphs a source and a target sinusoidal breakpoint into one breakpoint.
// ----------------------------------------------------------------------------
module sinusoid_breakpoint_morph_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sbm_pkg::AMP_W-1:0]          cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [sbm_pkg::FREQ_W-1:0]         src_freq_i,
  input  wire logic [sbm_pkg::AMP_W-1:0]          src_amp_i,
  input  wire logic [sbm_pkg::BW_W-1:0]           src_bw_i,
  input  wire logic signed [sbm_pkg::PH_W-1:0]    src_phase_i,
  input  wire logic [sbm_pkg::FREQ_W-1:0]         tgt_freq_i,
  input  wire logic [sbm_pkg::AMP_W-1:0]          tgt_amp_i,
  input  wire logic [sbm_pkg::BW_W-1:0]           tgt_bw_i,
  input  wire logic signed [sbm_pkg::PH_W-1:0]    tgt_phase_i,
  input  wire logic [sbm_pkg::W_W-1:0]            alpha_freq_i,
  input  wire logic [sbm_pkg::W_W-1:0]            alpha_amp_i,
  input  wire logic [sbm_pkg::W_W-1:0]            alpha_bw_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [sbm_pkg::FREQ_W-1:0]              out_freq_o,
  output logic [sbm_pkg::AMP_W-1:0]               out_amp_o,
  output logic [sbm_pkg::BW_W-1:0]                out_bw_o,
  output logic signed [sbm_pkg::PH_W-1:0]         out_phase_o
);

  logic                        en;
  logic [sbm_pkg::NSTG:1]      vld_q;
  logic [sbm_pkg::AMP_W-1:0]   amp_shape_q;
  logic [sbm_pkg::AMP_W-1:0]   s_eff;

  assign en          = !vld_q[sbm_pkg::NSTG] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign s_eff = (amp_shape_q == '0) ? sbm_pkg::AMP_W'(1) : amp_shape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_shape_q <= sbm_pkg::SHAPE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      amp_shape_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[sbm_pkg::NSTG-1:1], in_valid_i};
    end
  end

  // ---- entry stage: clamps, linear blends, phase unwrap, amp bypass ----
  logic [sbm_pkg::W_W-1:0]    wf, wa, wb, b0, b1, wf_n, wb_n;
  logic [40:0]                fsum;
  logic [33:0]                bsum;
  logic signed [sbm_pkg::PADJ_W-1:0] d, p0a;
  sbm_pkg::side_t             side_d;
  logic [sbm_pkg::X_W-1:0]    x0_d, x1_d;

  function automatic logic [sbm_pkg::W_W-1:0] clamp_w(input logic [sbm_pkg::W_W-1:0] w);
    return (w > sbm_pkg::W_ONE) ? sbm_pkg::W_ONE : w;
  endfunction

  always_comb begin
    wf = clamp_w(alpha_freq_i);
    wa = clamp_w(alpha_amp_i);
    wb = clamp_w(alpha_bw_i);
    b0 = clamp_w(src_bw_i);
    b1 = clamp_w(tgt_bw_i);
    wf_n = sbm_pkg::W_ONE - wf;
    wb_n = sbm_pkg::W_ONE - wb;
    fsum = 41'(wf) * 41'(tgt_freq_i) + 41'(wf_n) * 41'(src_freq_i) + 41'd32768;
    bsum = 34'(wb) * 34'(b1) + 34'(wb_n) * 34'(b0) + 34'd32768;

    // move source phase within half a turn of the target
    d = sbm_pkg::PADJ_W'(src_phase_i) - sbm_pkg::PADJ_W'(tgt_phase_i);
    p0a = sbm_pkg::PADJ_W'(src_phase_i);
    if (d > sbm_pkg::PADJ_W'(98304)) begin
      p0a = p0a - sbm_pkg::PADJ_W'(131072);
    end else if (d > sbm_pkg::PADJ_W'(32768)) begin
      p0a = p0a - sbm_pkg::PADJ_W'(65536);
    end else if (d < -sbm_pkg::PADJ_W'(98304)) begin
      p0a = p0a + sbm_pkg::PADJ_W'(131072);
    end else if (d < -sbm_pkg::PADJ_W'(32768)) begin
      p0a = p0a + sbm_pkg::PADJ_W'(65536);
    end

    side_d.freq  = fsum[39:16];
    side_d.bw    = bsum[32:16];
    side_d.phase = '0;
    side_d.wa    = wa;
    side_d.byp   = 1'b1;
    if (src_amp_i == '0 && tgt_amp_i == '0) begin
      side_d.byp_val = '0;
    end else if (wa == '0) begin
      side_d.byp_val = src_amp_i;
    end else if (wa == sbm_pkg::W_ONE) begin
      side_d.byp_val = tgt_amp_i;
    end else begin
      side_d.byp     = 1'b0;
      side_d.byp_val = '0;
    end

    x0_d = sbm_pkg::X_W'(src_amp_i) + sbm_pkg::X_W'(s_eff);
    x1_d = sbm_pkg::X_W'(tgt_amp_i) + sbm_pkg::X_W'(s_eff);
  end

  sbm_pkg::side_t                    side_q [1:sbm_pkg::STG_EXP_OUT];
  logic [sbm_pkg::X_W-1:0]           x0_q, x1_q;
  logic signed [sbm_pkg::PADJ_W-1:0] p0_q;
  logic signed [sbm_pkg::PH_W-1:0]   p1_q;
  logic [sbm_pkg::W_W-1:0]           wf_q;
  logic signed [sbm_pkg::PB_W-1:0]   pb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      x0_q      <= x0_d;
      x1_q      <= x1_d;
      p0_q      <= p0a;
      p1_q      <= tgt_phase_i;
      wf_q      <= wf;
    end
  end

  // ---- phase blend, then round and signed remainder ----
  logic signed [sbm_pkg::PB_W-1:0] pb_d, pt;
  logic signed [sbm_pkg::PB_W-17:0] pv;
  logic [sbm_pkg::PB_W-17:0]        pmag;
  sbm_pkg::side_t                   side3_d;

  always_comb begin
    pb_d = sbm_pkg::PB_W'($signed({1'b0, wf_q})) * sbm_pkg::PB_W'(p1_q)
         + sbm_pkg::PB_W'($signed({1'b0, sbm_pkg::W_ONE - wf_q})) * sbm_pkg::PB_W'(p0_q);
    pt = pb_q + sbm_pkg::PB_W'(32768);
    pv = pt[sbm_pkg::PB_W-1:16];
    side3_d = side_q[2];
    if (pv < 0) begin
      pmag = (-pv) & (sbm_pkg::PB_W-16)'(16'hFFFF);
      side3_d.phase = -sbm_pkg::PH_W'(pmag);
    end else begin
      pmag = pv & (sbm_pkg::PB_W-16)'(16'hFFFF);
      side3_d.phase = sbm_pkg::PH_W'(pmag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[2] <= side_q[1];
      pb_q      <= pb_d;
      side_q[3] <= side3_d;
    end
  end

  for (genvar k = 4; k <= sbm_pkg::STG_EXP_OUT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---- amplitude: log2 of both, blend, exp2 ----
  logic [sbm_pkg::LOG_W-1:0] l0, l1, lm_q, r_exp;
  logic [sbm_pkg::W_W-1:0]   wa_b;
  logic [49:0]               lsum;

  sbm_log2 u_log_src (.clk_i(clk_i), .en_i(en), .x_i(x0_q), .l_o(l0));
  sbm_log2 u_log_tgt (.clk_i(clk_i), .en_i(en), .x_i(x1_q), .l_o(l1));

  always_comb begin
    wa_b = side_q[sbm_pkg::STG_LOG_OUT].wa;
    lsum = 50'(wa_b) * 50'(l1) + 50'(sbm_pkg::W_ONE - wa_b) * 50'(l0) + 50'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lm_q <= lsum[sbm_pkg::LOG_W+15:16];
    end
  end

  sbm_exp2 u_exp (.clk_i(clk_i), .en_i(en), .l_i(lm_q), .r_o(r_exp));

  // ---- output register: bypass value, or remove offset, clamp, saturate ----
  sbm_pkg::side_t            so;
  logic [sbm_pkg::AMP_W-1:0] amp_d;
  logic [sbm_pkg::LOG_W-1:0] rs;

  always_comb begin
    so = side_q[sbm_pkg::STG_EXP_OUT];
    rs = r_exp - sbm_pkg::LOG_W'(s_eff);
    if (so.byp) begin
      amp_d = so.byp_val;
    end else if (r_exp <= sbm_pkg::LOG_W'(s_eff)) begin
      amp_d = '0;
    end else if (rs > sbm_pkg::LOG_W'(sbm_pkg::AMP_MAX)) begin
      amp_d = sbm_pkg::AMP_MAX;
    end else begin
      amp_d = rs[sbm_pkg::AMP_W-1:0];
    end
  end

  logic [sbm_pkg::FREQ_W-1:0]      freq_q;
  logic [sbm_pkg::AMP_W-1:0]       amp_q;
  logic [sbm_pkg::BW_W-1:0]        bw_q;
  logic signed [sbm_pkg::PH_W-1:0] ph_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      freq_q <= so.freq;
      amp_q  <= amp_d;
      bw_q   <= so.bw;
      ph_q   <= so.phase;
    end
  end

  assign out_valid_o = vld_q[sbm_pkg::NSTG];
  assign out_freq_o  = freq_q;
  assign out_amp_o   = amp_q;
  assign out_bw_o    = bw_q;
  assign out_phase_o = ph_q;

  `SBM_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en, $stable(vld_q))
  `SBM_ASSERT_NOW(a_phase_range, clk_i, rst_ni, out_valid_o, out_phase_o != -sbm_pkg::PH_W'(65536))
  `SBM_ASSERT_NOW(a_bw_range, clk_i, rst_ni, out_valid_o, out_bw_o <= sbm_pkg::W_ONE)

endmodule

`default_nettype wire

// ===== bench/sinusoid_breakpoint_morph_core_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// sinusoid_breakpoint_morph_core_tb
// Streams breakpoint pairs through the morpher and checks every morphed
// breakpoint against a fixed-point predictor, under bursty input and stalls.
// ----------------------------------------------------------------------------
module sinusoid_breakpoint_morph_core_tb;

  localparam int FREQ_W   = sbm_pkg::FREQ_W;
  localparam int AMP_W    = sbm_pkg::AMP_W;
  localparam int BW_W     = sbm_pkg::BW_W;
  localparam int PH_W     = sbm_pkg::PH_W;
  localparam int W_W      = sbm_pkg::W_W;
  localparam int LOG_FRAC = sbm_pkg::LOG_FRAC;
  localparam logic [W_W-1:0]   W_ONE     = sbm_pkg::W_ONE;
  localparam logic [AMP_W-1:0] AMP_MAX   = sbm_pkg::AMP_MAX;
  localparam logic [AMP_W-1:0] SHAPE_RST = sbm_pkg::SHAPE_RST;

  typedef struct {
    logic [FREQ_W-1:0] src_freq;
    logic [AMP_W-1:0]  src_amp;
    logic [BW_W-1:0]   src_bw;
    logic [PH_W-1:0]   src_phase;
    logic [FREQ_W-1:0] tgt_freq;
    logic [AMP_W-1:0]  tgt_amp;
    logic [BW_W-1:0]   tgt_bw;
    logic [PH_W-1:0]   tgt_phase;
    logic [W_W-1:0]    alpha_freq;
    logic [W_W-1:0]    alpha_amp;
    logic [W_W-1:0]    alpha_bw;
  } bp_pair_t;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;
    logic [BW_W-1:0]   bw;
    logic [PH_W-1:0]   phase;
  } bp_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [AMP_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [FREQ_W-1:0] src_freq_i = '0;
  logic [AMP_W-1:0] src_amp_i = '0;
  logic [BW_W-1:0] src_bw_i = '0;
  logic signed [PH_W-1:0] src_phase_i = '0;
  logic [FREQ_W-1:0] tgt_freq_i = '0;
  logic [AMP_W-1:0] tgt_amp_i = '0;
  logic [BW_W-1:0] tgt_bw_i = '0;
  logic signed [PH_W-1:0] tgt_phase_i = '0;
  logic [W_W-1:0] alpha_freq_i = '0;
  logic [W_W-1:0] alpha_amp_i = '0;
  logic [W_W-1:0] alpha_bw_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [FREQ_W-1:0] out_freq_o;
  logic [AMP_W-1:0] out_amp_o;
  logic [BW_W-1:0] out_bw_o;
  logic signed [PH_W-1:0] out_phase_o;

  sinusoid_breakpoint_morph_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bp_out_t morph_q[$];
  logic [AMP_W-1:0] shape_reg = SHAPE_RST;
  int errors = 0;
  int hold_cycles = 0;

  // ---------------- predictor ----------------
  function automatic logic [63:0] root_floor(logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] blend_lin(logic [63:0] v0, logic [63:0] v1,
                                            logic [63:0] w);
    return (w * v1 + (64'd65536 - w) * v0 + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] weight_clamp(logic [W_W-1:0] w);
    return (w > W_ONE) ? 64'd65536 : 64'(w);
  endfunction

  function automatic logic [63:0] log2_q28(logic [63:0] x);
    int unsigned e;
    logic [63:0] m, res;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
    res = 64'(e) << LOG_FRAC;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        res = res | (64'd1 << (LOG_FRAC - i));
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] exp2_q28(logic [63:0] l);
    logic [63:0] n, acc, fac;
    n = l >> LOG_FRAC;
    acc = 64'd1 << 31;
    fac = 64'd1 << 32;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      fac = root_floor(fac << 31);
      if ((l >> (LOG_FRAC - i)) & 64'd1) acc = (acc * fac) >> 31;
    end
    if (n >= 31) begin
      if (n > 40) n = 40;
      return acc << (n - 31);
    end
    return (acc + (64'd1 << (30 - n))) >> (31 - n);
  endfunction

  function automatic logic [AMP_W-1:0] amp_morph(logic [63:0] a0, logic [63:0] a1,
                                                 logic [63:0] w);
    logic [63:0] s, r;
    s = (shape_reg == 0) ? 64'd1 : 64'(shape_reg);
    if (a0 == 0 && a1 == 0) return '0;
    if (w == 0) return a0[AMP_W-1:0];
    if (w == 64'd65536) return a1[AMP_W-1:0];
    r = exp2_q28(blend_lin(log2_q28(a0 + s), log2_q28(a1 + s), w));
    r = (r > s) ? r - s : 64'd0;
    return (r > 64'(AMP_MAX)) ? AMP_MAX : r[AMP_W-1:0];
  endfunction

  function automatic logic [PH_W-1:0] phase_morph(logic signed [PH_W-1:0] ps0,
                                                  logic signed [PH_W-1:0] ps1,
                                                  logic [63:0] w);
    longint p0, p1, b, v;
    p0 = longint'(ps0);
    p1 = longint'(ps1);
    while (p0 - p1 > 32768) p0 -= 65536;
    while (p1 - p0 > 32768) p0 += 65536;
    b = longint'(w) * p1 + longint'(64'd65536 - w) * p0;
    v = ((b + 4 * 65536 * 64'sd65536 + 32768) >>> 16) - 4 * 65536;
    v = v % 65536;
    return v[PH_W-1:0];
  endfunction

  function automatic bp_out_t morph_breakpoint(bp_pair_t p);
    bp_out_t r;
    logic [63:0] wf;
    wf = weight_clamp(p.alpha_freq);
    r.freq = FREQ_W'(blend_lin(64'(p.src_freq), 64'(p.tgt_freq), wf));
    r.amp = amp_morph(64'(p.src_amp), 64'(p.tgt_amp), weight_clamp(p.alpha_amp));
    r.bw = BW_W'(blend_lin(weight_clamp(p.src_bw), weight_clamp(p.tgt_bw),
                           weight_clamp(p.alpha_bw)));
    r.phase = phase_morph(p.src_phase, p.tgt_phase, wf);
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string fld, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", fld, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i) begin
    bp_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (morph_q.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_freq_o), 0);
      end else begin
        e = morph_q.pop_front();
        if (out_freq_o !== e.freq) report_mismatch("freq", 32'(out_freq_o), 32'(e.freq));
        if (out_amp_o !== e.amp) report_mismatch("amp", 32'(out_amp_o), 32'(e.amp));
        if (out_bw_o !== e.bw) report_mismatch("bw", 32'(out_bw_o), 32'(e.bw));
        if (out_phase_o !== e.phase)
          report_mismatch("phase", 32'(out_phase_o), 32'(e.phase));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    int mode, left;
    if (left <= 0) begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(8, 64);
    end
    left--;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 7) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_pair(bp_pair_t p);
    in_valid_i <= 1'b1;
    src_freq_i <= p.src_freq;
    src_amp_i <= p.src_amp;
    src_bw_i <= p.src_bw;
    src_phase_i <= p.src_phase;
    tgt_freq_i <= p.tgt_freq;
    tgt_amp_i <= p.tgt_amp;
    tgt_bw_i <= p.tgt_bw;
    tgt_phase_i <= p.tgt_phase;
    alpha_freq_i <= p.alpha_freq;
    alpha_amp_i <= p.alpha_amp;
    alpha_bw_i <= p.alpha_bw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    morph_q.insert(morph_q.size(), morph_breakpoint(p));
  endtask

  task automatic idle_input(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (morph_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_shape(logic [AMP_W-1:0] v);
    drain_wait();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shape_reg = v;
  endtask

  function automatic logic [W_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return W_ONE;
      2: return W_W'($urandom_range(65537, 131071));
      default: return W_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] rand_amp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return AMP_MAX;
      2: return AMP_W'($urandom_range(0, 1023));
      default: return AMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [BW_W-1:0] rand_bw();
    return ($urandom_range(0, 5) == 0) ? BW_W'($urandom) : BW_W'($urandom_range(0, 65536));
  endfunction

  function automatic bp_pair_t rand_pair();
    bp_pair_t p;
    p.src_freq = FREQ_W'($urandom);
    p.tgt_freq = FREQ_W'($urandom);
    p.src_amp = rand_amp();
    p.tgt_amp = ($urandom_range(0, 9) == 0) ? '0 : rand_amp();
    p.src_bw = rand_bw();
    p.tgt_bw = rand_bw();
    p.src_phase = PH_W'($urandom);
    p.tgt_phase = PH_W'($urandom);
    p.alpha_freq = rand_weight();
    p.alpha_amp = rand_weight();
    p.alpha_bw = rand_weight();
    return p;
  endfunction

  function automatic bp_pair_t mk_pair(logic [FREQ_W-1:0] f0, logic [AMP_W-1:0] a0,
      logic [BW_W-1:0] b0, logic [PH_W-1:0] p0, logic [FREQ_W-1:0] f1,
      logic [AMP_W-1:0] a1, logic [BW_W-1:0] b1, logic [PH_W-1:0] p1,
      logic [W_W-1:0] wf, logic [W_W-1:0] wa, logic [W_W-1:0] wb);
    bp_pair_t p;
    p = '{f0, a0, b0, p0, f1, a1, b1, p1, wf, wa, wb};
    return p;
  endfunction

  task automatic test_field_extremes();
    send_pair(mk_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_pair(mk_pair('1, AMP_MAX, W_ONE, 17'h0ffff, '1, AMP_MAX, W_ONE, 17'h10000,
                      W_ONE, 17'd32768, W_ONE));
    send_pair(mk_pair('0, '0, '0, 17'h10000, '1, AMP_MAX, W_ONE, 17'h0ffff,
                      17'd32768, 17'd32768, 17'd32768));
    send_pair(mk_pair('1, 24'd1, '1, '1, '0, 24'd0, '1, '1, '1, '1, '1));
    send_pair(mk_pair(24'd1000, 24'd12345, 17'd100, 17'd32768, 24'd5000, 24'd999999,
                      17'd60000, 17'h18000, 17'd1, 17'd65535, 17'd1));
    send_pair(mk_pair(24'd7, AMP_MAX, 17'd0, 17'd16384, 24'd9, 24'd1, 17'd1, 17'h1c000,
                      17'd65535, 17'd1, 17'd65535));
    idle_input(3);
  endtask

  task automatic test_amp_special();
    // both amplitudes zero, weight at its ends returning an input exactly, and one amplitude zero
    send_pair(mk_pair(24'd1, '0, '0, '0, 24'd2, '0, '0, '0, '0, 17'd40000, '0));
    send_pair(mk_pair(24'd1, 24'd777, '0, '0, 24'd2, 24'd888, '0, '0, '0, '0, '0));
    send_pair(mk_pair(24'd1, 24'd777, '0, '0, 24'd2, 24'd888, '0, '0, '0, W_ONE, '0));
    send_pair(mk_pair(24'd1, '0, '0, '0, 24'd2, AMP_MAX, '0, '0, '0, 17'd20000, '0));
    send_pair(mk_pair(24'd1, AMP_MAX, '0, '0, 24'd2, '0, '0, '0, '0, 17'd50000, '0));
    idle_input(2);
  endtask

  task automatic test_weight_clamp();
    // weights and bandwidths above one saturate
    send_pair(mk_pair(24'd10, 24'd5000, 17'h1ffff, 17'd1000, 24'd20, 24'd70000,
                      17'h10001, 17'h1f000, 17'h1ffff, 17'h10001, 17'h18000));
    send_pair(mk_pair(24'd10, 24'd5000, 17'h10001, 17'h1f000, 24'd20, 24'd70000,
                      17'd0, 17'd1000, 17'h10001, 17'h1ffff, 17'h10001));
    idle_input(1);
  endtask

  task automatic test_shape_settings();
    logic [AMP_W-1:0] shapes [5];
    shapes = '{24'd1, AMP_MAX, 24'd0, 24'd4096, SHAPE_RST};
    foreach (shapes[k]) begin
      write_shape(shapes[k]);
      send_pair(mk_pair(24'd100, 24'd3000, '0, '0, 24'd200, 24'd900000, '0, '0,
                        17'd30000, 17'd30000, 17'd30000));
      send_pair(mk_pair(24'd100, '0, '0, '0, 24'd200, AMP_MAX, '0, '0,
                        17'd30000, 17'd1, 17'd30000));
    end
    idle_input(1);
  endtask

  task automatic test_backpressure();
    // receiver holds off long enough for the pipeline to fill and stall input
    drain_wait();
    hold_cycles = 300;
    repeat (150) send_pair(rand_pair());
    drain_wait();
  endtask

  task automatic test_random_stream();
    int sent;
    sent = 0;
    while (sent < 1120) begin
      if (sent % 250 == 0) begin
        if ($urandom_range(0, 1)) write_shape(AMP_W'($urandom_range(1, 16777215)));
        else write_shape(AMP_W'($urandom_range(1, 2000)));
      end
      repeat ($urandom_range(1, 40)) begin
        send_pair(rand_pair());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    write_shape(SHAPE_RST);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_amp_special();
    test_weight_clamp();
    test_shape_settings();
    test_backpressure();
    test_random_stream();
    drain_wait();
    repeat (80) @(posedge clk_i);
    if (errors == 0 && morph_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sinusoid_breakpoint_morph_core.f =====
+incdir+rtl
rtl/sbm_pkg.sv
rtl/sbm_log2.sv
rtl/sbm_exp2.sv
rtl/sinusoid_breakpoint_morph_core.sv
bench/sinusoid_breakpoint_morph_core_tb.sv
